// ===== design/track_nucleus_intensity_map_top_assert.svh =====
// assertion macros for the checker file
`ifndef TRACK_NUCLEUS_INTENSITY_MAP_TOP_ASSERT_SVH
`define TRACK_NUCLEUS_INTENSITY_MAP_TOP_ASSERT_SVH

// clocked assertion, off while reset is low
`define TNIM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TNIM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tnim_pkg.sv =====
`timescale 1ns / 1ps

package tnim_pkg;

  localparam int MAX_NUCLEI      = 256;
  localparam int COS_TABLE_DEPTH = 256;  // power of two
  localparam int IDX_W           = $clog2(MAX_NUCLEI);
  localparam int CNT_W           = $clog2(MAX_NUCLEI + 1);
  localparam int K_W             = $clog2(COS_TABLE_DEPTH);
  localparam int ROOT_STEPS      = 32;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [8:0]  TOUCH_MAX = 9'd511;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_DIR_X   = 2'd0,
    REG_DIR_Y   = 2'd1,
    REG_DIR_Z   = 2'd2,
    REG_IFACE_W = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DOT,
    ST_TRUNC,
    ST_PROJ,
    ST_SQR,
    ST_ROOT,
    ST_CLASS,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [30:0]        rad;
    logic signed [31:0] cz;
    logic signed [31:0] cy;
    logic signed [31:0] cx;
  } nucleus_t;

  typedef logic [COS_TABLE_DEPTH-1:0][16:0] cos_rom_t;

  // (1+cos(pi*k/D))/2 in Q1.16, taylor series in Q2.30
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t           rom;
    logic [63:0]        m;
    logic [63:0]        phi;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] c;
    logic signed [63:0] s;
    logic               upper;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      m     = 64'(k);
      upper = 1'b0;
      if (2 * k > COS_TABLE_DEPTH) begin
        m     = 64'(COS_TABLE_DEPTH - k);
        upper = 1'b1;
      end
      phi  = (PI_Q30 * m) / COS_TABLE_DEPTH;
      x2   = (phi * phi) >> 30;
      term = ONE_Q30;
      c    = $signed(ONE_Q30);
      for (int n = 0; n < 10; n++) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[n];
        if (n % 2 == 0) c = c - $signed(term);
        else            c = c + $signed(term);
      end
      if (upper) c = -c;
      s = $signed(ONE_Q30) + c + 64'sd16384;
      if (s < 0) s = 64'sd0;
      s = s >>> 15;
      if (s > 64'sd65536) s = 64'sd65536;
      rom[k] = s[16:0];
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // shift right by 14, halves away from zero
  function automatic logic signed [68:0] round_q14(input logic signed [68:0] v);
    logic [68:0] mag;
    mag = v[68] ? 69'(-v) : 69'(v);
    mag = (mag + 69'd8192) >> 14;
    return v[68] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== design/track_nucleus_intensity_map_top.sv =====
`timescale 1ns / 1ps
// channel   direction  payload
// s_axis    in         tdata: pos_x, pos_y, pos_z, nucleus_radius; tuser: operation
// m_axis    out        tdata: intensity, touching_count
// cfg       in         cfg_we_i / cfg_addr_i / cfg_wdata_i, write only
//
// clear and append are taken while idle; a query runs through every stored nucleus,
// with the divider used only when the point falls in the interface. a query's length
// is set by the shared multiplier doing nine products per nucleus, the one bit per
// cycle square root and the eight step divider.
// reset is asynchronous, active low; it empties the table and loads register defaults.
// a finished result waits in the output register; the next request is taken meanwhile.

module track_nucleus_intensity_map_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [30:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // pos_x, pos_y, pos_z, nucleus_radius, pad
  input  logic [1:0]   s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // intensity, touching_count, pad
);

  tnim_pkg::state_e state_q, state_d;
  logic [4:0]       step_q, step_d;

  // configuration
  logic signed [15:0] dir_x_q, dir_y_q, dir_z_q;
  logic [30:0]        iw_q;

  // table
  tnim_pkg::nucleus_t mem [tnim_pkg::MAX_NUCLEI];
  tnim_pkg::nucleus_t rdata_q;
  tnim_pkg::nucleus_t wr_entry;
  logic [tnim_pkg::CNT_W-1:0] count_q;
  logic [tnim_pkg::CNT_W-1:0] idx_q;

  // query datapath
  logic signed [31:0] qx_q, qy_q, qz_q;
  logic [30:0]        rad_q;
  logic signed [32:0] d_q [3];
  logic signed [49:0] acc_q;
  logic signed [34:0] t_q;
  logic [31:0]        pa_q [3];
  logic signed [68:0] prod_q;
  logic [63:0]        sum_q;
  logic [63:0]        rem_q, res_q, bit_q;
  logic [33:0]        div_rem_q;
  logic [tnim_pkg::K_W-1:0] quo_q;
  logic [16:0]        val_q;
  logic               from_div_q, touch_q;
  logic [16:0]        best_q;
  logic [8:0]         touching_q;

  // output register
  logic        out_valid_q;
  logic [16:0] out_int_q;
  logic [8:0]  out_cnt_q;

  logic in_acc, out_acc, out_load, is_last, app_ok;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = out_valid_q && m_axis_tready;
  assign out_load = (state_q == tnim_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
  assign is_last  = (idx_q + tnim_pkg::CNT_W'(1)) == count_q;
  assign app_ok   = count_q < tnim_pkg::CNT_W'(tnim_pkg::MAX_NUCLEI);

  assign s_axis_tready = (state_q == tnim_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_cnt_q, out_int_q};

  assign wr_entry.cx  = s_axis_tdata[31:0];
  assign wr_entry.cy  = s_axis_tdata[63:32];
  assign wr_entry.cz  = s_axis_tdata[95:64];
  assign wr_entry.rad = s_axis_tdata[126:96];

  // operand select for the shared multiplier
  logic [1:0]         sel, prev_sel;
  logic signed [32:0] d_sel, d_prev;
  logic signed [15:0] dir_sel;
  logic [31:0]        pa_sel;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod;

  assign sel      = step_q[1:0];
  assign prev_sel = step_q[1:0] - 2'd1;

  always_comb begin
    d_sel   = '0;
    dir_sel = '0;
    pa_sel  = '0;
    unique case (sel)
      2'd0: begin d_sel = d_q[0]; dir_sel = dir_x_q; pa_sel = pa_q[0]; end
      2'd1: begin d_sel = d_q[1]; dir_sel = dir_y_q; pa_sel = pa_q[1]; end
      2'd2: begin d_sel = d_q[2]; dir_sel = dir_z_q; pa_sel = pa_q[2]; end
      default: ;
    endcase
  end

  always_comb begin
    unique case (prev_sel)
      2'd0:    d_prev = d_q[0];
      2'd1:    d_prev = d_q[1];
      2'd2:    d_prev = d_q[2];
      default: d_prev = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      tnim_pkg::ST_DOT: begin
        mul_a = {{3{d_sel[32]}}, d_sel};
        mul_b = {{17{dir_sel[15]}}, dir_sel};
      end
      tnim_pkg::ST_PROJ: begin
        mul_a = {t_q[34], t_q};
        mul_b = {{17{dir_sel[15]}}, dir_sel};
      end
      tnim_pkg::ST_SQR: begin
        mul_a = {4'd0, pa_sel};
        mul_b = {1'b0, pa_sel};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // shared rounding, projection and squared sum
  logic signed [68:0] rnd_in, rnd;
  logic signed [35:0] psum;
  logic [35:0]        pabs;
  logic [31:0]        psat;
  logic [64:0]        s_add;
  logic [63:0]        s_sat;

  assign rnd_in = (state_q == tnim_pkg::ST_TRUNC) ? {{19{acc_q[49]}}, acc_q} : prod_q;
  assign rnd    = tnim_pkg::round_q14(rnd_in);
  assign psum   = {{3{d_prev[32]}}, d_prev} + rnd[35:0];
  assign pabs   = psum[35] ? 36'(-psum) : 36'(psum);
  assign psat   = (pabs[35:32] != 4'd0) ? 32'hFFFF_FFFF : pabs[31:0];
  assign s_add  = {1'b0, sum_q} + {1'b0, prod_q[63:0]};
  assign s_sat  = s_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s_add[63:0];

  // square root step
  logic [63:0] trial;
  logic        root_ge;
  assign trial   = res_q + bit_q;
  assign root_ge = rem_q >= trial;

  // classification against radius and interface
  logic signed [34:0] r2, big_r2, wide_w, num;
  logic               in_core, in_iface;
  assign r2       = {2'd0, res_q[31:0], 1'b0};
  assign big_r2   = {3'd0, rad_q, 1'b0};
  assign wide_w   = {4'd0, iw_q};
  assign in_core  = r2 <= (big_r2 - wide_w);
  assign in_iface = r2 < (big_r2 + wide_w);
  assign num      = r2 - big_r2 + wide_w;

  // divider step, quotient of num * depth / (2 * width)
  logic [34:0] cand;
  logic        div_ge;
  logic [34:0] cand_sub;
  assign cand     = (step_q == 5'd0) ? {1'b0, div_rem_q} : {div_rem_q, 1'b0};
  assign div_ge   = cand >= {4'd0, iw_q};
  assign cand_sub = cand - {4'd0, iw_q};

  logic [16:0] acc_val;
  assign acc_val = from_div_q ? tnim_pkg::COS_ROM[quo_q] : val_q;

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q + 5'd1;
    unique case (state_q)
      tnim_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_acc && s_axis_tuser == tnim_pkg::OP_QUERY) begin
          state_d = (count_q == '0) ? tnim_pkg::ST_DONE : tnim_pkg::ST_READ;
        end
      end
      tnim_pkg::ST_READ: begin
        state_d = tnim_pkg::ST_LOAD;
        step_d  = '0;
      end
      tnim_pkg::ST_LOAD: begin
        state_d = tnim_pkg::ST_DOT;
        step_d  = '0;
      end
      tnim_pkg::ST_DOT: begin
        if (step_q == 5'd3) begin
          state_d = tnim_pkg::ST_TRUNC;
          step_d  = '0;
        end
      end
      tnim_pkg::ST_TRUNC: begin
        state_d = tnim_pkg::ST_PROJ;
        step_d  = '0;
      end
      tnim_pkg::ST_PROJ: begin
        if (step_q == 5'd3) begin
          state_d = tnim_pkg::ST_SQR;
          step_d  = '0;
        end
      end
      tnim_pkg::ST_SQR: begin
        if (step_q == 5'd3) begin
          state_d = tnim_pkg::ST_ROOT;
          step_d  = '0;
        end
      end
      tnim_pkg::ST_ROOT: begin
        if (step_q == 5'(tnim_pkg::ROOT_STEPS - 1)) begin
          state_d = tnim_pkg::ST_CLASS;
          step_d  = '0;
        end
      end
      tnim_pkg::ST_CLASS: begin
        step_d  = '0;
        state_d = (!in_core && in_iface) ? tnim_pkg::ST_DIV : tnim_pkg::ST_ACC;
      end
      tnim_pkg::ST_DIV: begin
        if (step_q == 5'(tnim_pkg::K_W - 1)) begin
          state_d = tnim_pkg::ST_ACC;
          step_d  = '0;
        end
      end
      tnim_pkg::ST_ACC: begin
        step_d  = '0;
        state_d = is_last ? tnim_pkg::ST_DONE : tnim_pkg::ST_READ;
      end
      tnim_pkg::ST_DONE: begin
        step_d = '0;
        if (out_load) state_d = tnim_pkg::ST_IDLE;
      end
      default: begin
        state_d = tnim_pkg::ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnim_pkg::ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      dir_x_q     <= 16'sd0;
      dir_y_q     <= 16'sd16384;
      dir_z_q     <= 16'sd0;
      iw_q        <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_acc && s_axis_tuser == tnim_pkg::OP_CLEAR) begin
        count_q <= '0;
      end else if (in_acc && s_axis_tuser == tnim_pkg::OP_APPEND && app_ok) begin
        count_q <= count_q + tnim_pkg::CNT_W'(1);
      end
      if (out_load)     out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          tnim_pkg::REG_DIR_X:   dir_x_q <= cfg_wdata_i[15:0];
          tnim_pkg::REG_DIR_Y:   dir_y_q <= cfg_wdata_i[15:0];
          tnim_pkg::REG_DIR_Z:   dir_z_q <= cfg_wdata_i[15:0];
          tnim_pkg::REG_IFACE_W: iw_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // nucleus table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == tnim_pkg::OP_APPEND && app_ok) begin
      mem[count_q[tnim_pkg::IDX_W-1:0]] <= wr_entry;
    end
    rdata_q <= mem[idx_q[tnim_pkg::IDX_W-1:0]];
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    unique case (state_q)
      tnim_pkg::ST_IDLE: begin
        if (in_acc) begin
          qx_q       <= s_axis_tdata[31:0];
          qy_q       <= s_axis_tdata[63:32];
          qz_q       <= s_axis_tdata[95:64];
          idx_q      <= '0;
          best_q     <= '0;
          touching_q <= '0;
        end
      end
      tnim_pkg::ST_LOAD: begin
        d_q[0] <= {rdata_q.cx[31], rdata_q.cx} - {qx_q[31], qx_q};
        d_q[1] <= {rdata_q.cy[31], rdata_q.cy} - {qy_q[31], qy_q};
        d_q[2] <= {rdata_q.cz[31], rdata_q.cz} - {qz_q[31], qz_q};
        rad_q  <= rdata_q.rad;
      end
      tnim_pkg::ST_DOT: begin
        if (step_q == 5'd1)      acc_q <= prod_q[49:0];
        else if (step_q != 5'd0) acc_q <= acc_q + prod_q[49:0];
      end
      tnim_pkg::ST_TRUNC: begin
        t_q <= -rnd[34:0];
      end
      tnim_pkg::ST_PROJ: begin
        if (step_q != 5'd0) begin
          unique case (prev_sel)
            2'd0:    pa_q[0] <= psat;
            2'd1:    pa_q[1] <= psat;
            2'd2:    pa_q[2] <= psat;
            default: ;
          endcase
        end
        if (step_q == 5'd3) sum_q <= '0;
      end
      tnim_pkg::ST_SQR: begin
        if (step_q == 5'd3) begin
          rem_q <= s_sat;
          res_q <= '0;
          bit_q <= 64'h4000_0000_0000_0000;
        end else if (step_q != 5'd0) begin
          sum_q <= s_sat;
        end
      end
      tnim_pkg::ST_ROOT: begin
        if (root_ge) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      tnim_pkg::ST_CLASS: begin
        div_rem_q  <= num[33:0];
        from_div_q <= !in_core && in_iface;
        touch_q    <= in_core || in_iface;
        val_q      <= in_core ? tnim_pkg::ONE_Q16 : 17'd0;
      end
      tnim_pkg::ST_DIV: begin
        div_rem_q <= div_ge ? cand_sub[33:0] : cand[33:0];
        quo_q     <= {quo_q[tnim_pkg::K_W-2:0], div_ge};
      end
      tnim_pkg::ST_ACC: begin
        if (acc_val > best_q) best_q <= acc_val;
        if (touch_q && touching_q != tnim_pkg::TOUCH_MAX) begin
          touching_q <= touching_q + 9'd1;
        end
        idx_q <= idx_q + tnim_pkg::CNT_W'(1);
      end
      tnim_pkg::ST_DONE: begin
        if (out_load) begin
          out_int_q <= best_q;
          out_cnt_q <= touching_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/tnim_checker.sv =====
`timescale 1ns / 1ps
`include "track_nucleus_intensity_map_top_assert.svh"

module tnim_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata
);

  // a stalled result stays offered
  `TNIM_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // a stalled result keeps its data
  `TNIM_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

  // a query keeps the block busy for at least the next cycle
  `TNIM_ASSERT(a_query_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser == tnim_pkg::OP_QUERY |=> !s_axis_tready, "request taken during query")

  // reset leaves no result offered
  `TNIM_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !m_axis_tvalid, "result offered in reset")

endmodule

bind track_nucleus_intensity_map_top tnim_checker u_tnim_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
